@@ design/c2p_pkg.sv @@
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared types for the chunky-to-planar scanline packer.
// ----------------------------------------------------------------------------
package c2p_pkg;

  localparam int ADDR_W  = 16;
  localparam int COLOR_W = 4;
  localparam int SX_W    = 11;
  localparam int ROW_W   = 10;
  localparam int CNT_W   = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [7:0]        plane0_byte;
    logic [7:0]        plane1_byte;
    logic [7:0]        plane2_byte;
    logic [7:0]        plane3_byte;
    logic [7:0]        write_mask;
    logic              last_write;
  } c2p_wr_t;

endpackage

@@ design/chunky_to_planar_scanline.sv @@
// ----------------------------------------------------------------------------
// chunky_to_planar_scanline
// Packs a stream of 4-bit pixels into 4-plane frame-buffer byte writes.
// ----------------------------------------------------------------------------
// One pixel is taken per cycle while pixel_ready is high. Each pixel is packed
// into the line state; a write word, when the pixel fills or ends a byte, goes
// straight into a two-entry output register/skid stage, so pixel_ready only
// drops while a stalled write channel has both entries held. A write waits in
// the skid stage while the channel stalls. Partial first and last bytes carry
// a write_mask that covers only the line's pixels.
module chunky_to_planar_scanline import c2p_pkg::*; #(
  parameter int MAX_LINE_PIXELS = 640,
  parameter int BYTES_PER_ROW   = 80
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  logic [COLOR_W-1:0] color,
  input  logic [SX_W-1:0]    start_x,
  input  logic [ROW_W-1:0]   row,
  input  logic               line_start,
  input  logic               line_end,
  output logic               write_valid,
  input  logic               write_ready,
  output logic [ADDR_W-1:0]  address,
  output logic [7:0]         plane0_byte,
  output logic [7:0]         plane1_byte,
  output logic [7:0]         plane2_byte,
  output logic [7:0]         plane3_byte,
  output logic [7:0]         write_mask,
  output logic               last_write
);

  logic    push;
  c2p_wr_t push_data;
  c2p_wr_t out_data;

  c2p_packer #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS),
    .BYTES_PER_ROW  (BYTES_PER_ROW)
  ) u_packer (
    .clk       (clk),
    .rst       (rst),
    .accept    (pixel_valid & pixel_ready),
    .color     (color),
    .start_x   (start_x),
    .row       (row),
    .line_start(line_start),
    .line_end  (line_end),
    .push      (push),
    .wr        (push_data)
  );

  c2p_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .can_accept(pixel_ready),
    .out_valid (write_valid),
    .out_ready (write_ready),
    .out_data  (out_data)
  );

  assign address     = out_data.address;
  assign plane0_byte = out_data.plane0_byte;
  assign plane1_byte = out_data.plane1_byte;
  assign plane2_byte = out_data.plane2_byte;
  assign plane3_byte = out_data.plane3_byte;
  assign write_mask  = out_data.write_mask;
  assign last_write  = out_data.last_write;

endmodule

@@ design/c2p_packer.sv @@
// ----------------------------------------------------------------------------
// c2p_packer
// Line state and per-pixel packing; emits one byte write per filled or final
// byte of a scanline.
// ----------------------------------------------------------------------------
module c2p_packer import c2p_pkg::*; #(
  parameter int MAX_LINE_PIXELS = 640,
  parameter int BYTES_PER_ROW   = 80
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [COLOR_W-1:0] color,
  input  logic [SX_W-1:0]    start_x,
  input  logic [ROW_W-1:0]   row,
  input  logic               line_start,
  input  logic               line_end,
  output logic               push,
  output c2p_wr_t            wr
);

  logic [31:0]       plane_accumulator;
  logic [2:0]        bit_position;
  logic [ADDR_W-1:0] byte_address;
  logic [2:0]        start_offset;
  logic              in_first_byte;
  logic [CNT_W-1:0]  pixel_count;
  logic              line_done;

  logic [25:0]       row_prod;
  logic [ADDR_W-1:0] line_addr;
  logic [ADDR_W-1:0] addr_base;
  logic [31:0]       acc_base;
  logic [31:0]       acc_new;
  logic [2:0]        pos;
  logic [2:0]        so;
  logic              first;
  logic [CNT_W-1:0]  cnt_next;
  logic              active;
  logic              full;
  logic              final_px;
  logic              emit;
  logic [2:0]        lo;
  logic [3:0]        endcnt;
  logic [7:0]        slot;

  always_comb begin
    row_prod  = 26'(row) * 26'(BYTES_PER_ROW);
    line_addr = row_prod[ADDR_W-1:0] + ADDR_W'(start_x[SX_W-1:3]);
    addr_base = line_start ? line_addr : byte_address;
    acc_base  = line_start ? 32'd0 : plane_accumulator;
    pos       = line_start ? start_x[2:0] : bit_position;
    so        = line_start ? start_x[2:0] : start_offset;
    first     = line_start | in_first_byte;
    cnt_next  = (line_start ? CNT_W'(0) : pixel_count) + CNT_W'(1);
    active    = line_start | ~line_done;
    slot      = 8'h80 >> pos;
    acc_new   = acc_base | { {8{color[3]}} & slot, {8{color[2]}} & slot,
                             {8{color[1]}} & slot, {8{color[0]}} & slot };
    full      = (pos == 3'd7);
    final_px  = line_end | (cnt_next >= CNT_W'(MAX_LINE_PIXELS));
    emit      = active & (full | final_px);
    lo        = first ? so : 3'd0;
    endcnt    = {1'b0, pos} + 4'd1;
  end

  assign push           = accept & emit;
  assign wr.address     = addr_base;
  assign wr.plane0_byte = acc_new[7:0];
  assign wr.plane1_byte = acc_new[15:8];
  assign wr.plane2_byte = acc_new[23:16];
  assign wr.plane3_byte = acc_new[31:24];
  assign wr.write_mask  = (8'hff >> lo) & ~(8'hff >> endcnt);
  assign wr.last_write  = final_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_accumulator <= '0;
      bit_position      <= '0;
      byte_address      <= '0;
      start_offset      <= '0;
      in_first_byte     <= 1'b1;
      pixel_count       <= '0;
      line_done         <= 1'b1;
    end else if (accept && active) begin
      start_offset <= so;
      pixel_count  <= cnt_next;
      if (emit) begin
        plane_accumulator <= '0;
        bit_position      <= '0;
        byte_address      <= addr_base + ADDR_W'(1);
        in_first_byte     <= 1'b0;
        line_done         <= final_px;
      end else begin
        plane_accumulator <= acc_new;
        bit_position      <= pos + 3'd1;
        byte_address      <= addr_base;
        in_first_byte     <= first;
        line_done         <= 1'b0;
      end
    end
  end

  a_mask_nonzero: assert property (@(posedge clk) disable iff (rst)
    push |-> wr.write_mask != 8'd0)
    else $error("empty write mask on emitted word");

  a_last_closes_line: assert property (@(posedge clk) disable iff (rst)
    push && wr.last_write |=> line_done)
    else $error("line still open after last write");

  a_pos_after_offset: assert property (@(posedge clk) disable iff (rst)
    !line_done && in_first_byte |-> bit_position >= start_offset)
    else $error("bit position before start offset in first byte");

endmodule

@@ design/c2p_out_buf.sv @@
// ----------------------------------------------------------------------------
// c2p_out_buf
// Output register with skid stage; decouples input acceptance from the
// write channel.
// ----------------------------------------------------------------------------
module c2p_out_buf import c2p_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  c2p_wr_t push_data,
  output logic    can_accept,
  output logic    out_valid,
  input  logic    out_ready,
  output c2p_wr_t out_data
);

  logic    skid_valid;
  c2p_wr_t skid_data;

  assign can_accept = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a word while output is empty");

endmodule
